/* rtl/shs_pkg.sv */
`timescale 1ns / 1ps

package shs_pkg;

    // Command codes carried in the cmd field of a request.
    localparam logic [2:0] CMD_START_IDX = 3'd0;
    localparam logic [2:0] CMD_START_PIX = 3'd1;
    localparam logic [2:0] CMD_GET       = 3'd2;
    localparam logic [2:0] CMD_WR_DIGIT  = 3'd3;
    localparam logic [2:0] CMD_WR_ORDER  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WIDTH_EXP      = 3'd0;
    localparam logic [2:0] CFG_HEIGHT_EXP     = 3'd1;
    localparam logic [2:0] CFG_WIDTH_ALIGNED  = 3'd2;
    localparam logic [2:0] CFG_HEIGHT_ALIGNED = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_STRIDE  = 3'd4;
    localparam logic [2:0] CFG_COEF_X         = 3'd5;
    localparam logic [2:0] CFG_COEF_Y         = 3'd6;

    // Kept digits are stacked so they can be folded back most significant first.
    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned STACK_AW    = 6;

    localparam int unsigned PRIME_COUNT = 168;

    localparam logic [9:0] PRIME_ROM [PRIME_COUNT] = '{
        10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
        10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
        10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
        10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
        10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
        10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
        10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
        10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
        10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
        10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
        10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
        10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
        10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
        10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
        10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
        10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
        10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769,
        10'd773, 10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827,
        10'd829, 10'd839, 10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881,
        10'd883, 10'd887, 10'd907, 10'd911, 10'd919, 10'd929, 10'd937, 10'd941,
        10'd947, 10'd953, 10'd967, 10'd971, 10'd977, 10'd983, 10'd991, 10'd997
    };

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] start_index;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [15:0] sample_number;
        logic [10:0] table_address;
        logic [7:0]  table_data;
    } shs_in_t;

    typedef struct packed {
        logic [31:0] sample_value;
        logic [7:0]  dimension_used;
    } shs_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PX_REV,
        ST_PX_MUL1,
        ST_PX_MUL2,
        ST_PX_SUM,
        ST_PX_CHK,
        ST_PX_MOD,
        ST_PX_MODW,
        ST_PX_FIX,
        ST_PX_FINAL,
        ST_G_BASE,
        ST_G_TLAT,
        ST_G_DIG,
        ST_G_DIGW,
        ST_G_DIGP,
        ST_G_DIGS,
        ST_G_FIRST,
        ST_G_ACCW,
        ST_G_ACC,
        ST_G_POP,
        ST_G_POPR,
        ST_G_OUT
    } shs_state_t;

    // Operand select for the shared digit divider.
    typedef enum logic [1:0] {
        DSEL_DIGIT,
        DSEL_FIRST,
        DSEL_ACC
    } shs_dsel_t;

    typedef struct packed {
        logic      accept;
        logic      load_idx;
        logic      wr_digit;
        logic      wr_order;
        logic      px_init;
        logic      px_step;
        logic      px_mul1;
        logic      px_mul2;
        logic      px_sum;
        logic      mod_start;
        logic      px_fix;
        logic      px_final;
        logic      get_sel;
        logic      t_latch;
        logic      div_start;
        shs_dsel_t dsel;
        logic      dig_take;
        logic      perm_digit;
        logic      dig_push;
        logic      q_latch;
        logic      pop;
        logic      out_load;
    } shs_cmd_t;

    typedef struct packed {
        logic [2:0] cmd_code;
        logic       px_done;
        logic       mix_neg;
        logic       stride_zero;
        logic       x_done;
        logic       n_zero;
        logic       div_busy;
        logic       mod_busy;
        logic       out_free;
    } shs_sts_t;

endpackage

/* rtl/scrambled_halton_sampler_core.sv */
`timescale 1ns / 1ps
// A start by index or a table write is done in the decode state; a pixel start runs bit and
// trit reversal, two multiply stages and, for a negative mix and nonzero stride, a modulo by
// the stride. A get divides out each base-b digit of the index, then folds back each kept
// digit, all on the shared 4-bit-per-cycle digit divider.
// Throughput: one request at a time; the next is taken while a result waits in the output.
// Reset: synchronous active-low aresetn resets index, dimension counter and config registers.
module scrambled_halton_sampler_core #(
    parameter int NUM_DIMS    = 32,
    parameter int DIGIT_STORE = 2048
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  shs_pkg::shs_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output shs_pkg::shs_out_t m_payload,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    import shs_pkg::*;

    shs_cmd_t cmd;
    shs_sts_t sts;

    // Configuration writes are always taken; the user must issue them only while idle.
    assign cfg_ready = 1'b1;

    // The controller sequences every request; it holds no payload of its own.
    shs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the sample index, the tables, both dividers and the result register.
    shs_dp #(
        .NUM_DIMS    (NUM_DIMS),
        .DIGIT_STORE (DIGIT_STORE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_payload (s_payload),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

/* rtl/shs_div.sv */
`timescale 1ns / 1ps

module shs_div #(
    parameter int DW  = 64,
    parameter int VW  = 10,
    parameter int SPC = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    // Restoring division, SPC quotient bits per cycle.
    localparam int ITER  = DW / SPC;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        logic [VW:0] t;
        t        = '0;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(ITER);
        end else if (cnt_reg != '0) begin
            for (int s = 0; s < SPC; s++) begin
                t        = {rem_next, quo_next[DW-1]};
                quo_next = {quo_next[DW-2:0], 1'b0};
                if (t >= {1'b0, dvs_reg}) begin
                    t           = t - {1'b0, dvs_reg};
                    quo_next[0] = 1'b1;
                end
                rem_next = t[VW-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Quotient and remainder start out defined so that status derived from
    // them is never unknown before the first division.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/shs_ctrl.sv */
`timescale 1ns / 1ps

module shs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  shs_pkg::shs_sts_t sts,
    output shs_pkg::shs_cmd_t cmd
);

    import shs_pkg::*;

    shs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.cmd_code)
                    CMD_START_PIX: state_next = ST_PX_REV;
                    CMD_GET:       state_next = ST_G_BASE;
                    default:       state_next = ST_IDLE;
                endcase
            end
            ST_PX_REV: begin
                if (sts.px_done) begin
                    state_next = ST_PX_MUL1;
                end
            end
            ST_PX_MUL1: state_next = ST_PX_MUL2;
            ST_PX_MUL2: state_next = ST_PX_SUM;
            ST_PX_SUM:  state_next = ST_PX_CHK;
            ST_PX_CHK: begin
                if (sts.mix_neg && !sts.stride_zero) begin
                    state_next = ST_PX_MOD;
                end else if (sts.mix_neg) begin
                    state_next = ST_PX_FIX;
                end else begin
                    state_next = ST_PX_FINAL;
                end
            end
            ST_PX_MOD: state_next = ST_PX_MODW;
            ST_PX_MODW: begin
                if (!sts.mod_busy) begin
                    state_next = ST_PX_FIX;
                end
            end
            ST_PX_FIX:   state_next = ST_PX_FINAL;
            ST_PX_FINAL: state_next = ST_IDLE;
            ST_G_BASE:   state_next = ST_G_TLAT;
            ST_G_TLAT:   state_next = ST_G_DIG;
            ST_G_DIG: begin
                if (sts.x_done) begin
                    state_next = ST_G_FIRST;
                end else begin
                    state_next = ST_G_DIGW;
                end
            end
            ST_G_DIGW: begin
                if (!sts.div_busy) begin
                    state_next = ST_G_DIGP;
                end
            end
            ST_G_DIGP:  state_next = ST_G_DIGS;
            ST_G_DIGS:  state_next = ST_G_DIG;
            ST_G_FIRST: state_next = ST_G_ACCW;
            ST_G_ACCW: begin
                if (!sts.div_busy) begin
                    state_next = ST_G_ACC;
                end
            end
            ST_G_ACC: state_next = ST_G_POP;
            ST_G_POP: begin
                if (sts.n_zero) begin
                    state_next = ST_G_OUT;
                end else begin
                    state_next = ST_G_POPR;
                end
            end
            ST_G_POPR: state_next = ST_G_ACCW;
            ST_G_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.dsel = DSEL_DIGIT;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_DECODE: begin
                case (sts.cmd_code)
                    CMD_START_IDX: cmd.load_idx = 1'b1;
                    CMD_START_PIX: cmd.px_init  = 1'b1;
                    CMD_GET:       cmd.get_sel  = 1'b1;
                    CMD_WR_DIGIT:  cmd.wr_digit = 1'b1;
                    CMD_WR_ORDER:  cmd.wr_order = 1'b1;
                    default:       cmd.load_idx = 1'b0;
                endcase
            end
            ST_PX_REV:   cmd.px_step   = !sts.px_done;
            ST_PX_MUL1:  cmd.px_mul1   = 1'b1;
            ST_PX_MUL2:  cmd.px_mul2   = 1'b1;
            ST_PX_SUM:   cmd.px_sum    = 1'b1;
            ST_PX_MOD:   cmd.mod_start = 1'b1;
            ST_PX_FIX:   cmd.px_fix    = 1'b1;
            ST_PX_FINAL: cmd.px_final  = 1'b1;
            ST_G_TLAT:   cmd.t_latch   = 1'b1;
            ST_G_DIG: begin
                cmd.div_start = !sts.x_done;
                cmd.dsel      = DSEL_DIGIT;
            end
            ST_G_DIGP: begin
                cmd.dig_take   = 1'b1;
                cmd.perm_digit = 1'b1;
            end
            ST_G_DIGS: cmd.dig_push = 1'b1;
            ST_G_FIRST: begin
                cmd.div_start = 1'b1;
                cmd.dsel      = DSEL_FIRST;
            end
            ST_G_ACC: cmd.q_latch = 1'b1;
            ST_G_POP: cmd.pop     = !sts.n_zero;
            ST_G_POPR: begin
                cmd.div_start = 1'b1;
                cmd.dsel      = DSEL_ACC;
            end
            ST_G_OUT: cmd.out_load = sts.out_free;
            default:  cmd.accept   = 1'b0;
        endcase
    end

endmodule

/* rtl/shs_dp.sv */
`timescale 1ns / 1ps

module shs_dp #(
    parameter int NUM_DIMS    = 32,
    parameter int DIGIT_STORE = 2048
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  shs_pkg::shs_cmd_t cmd,
    output shs_pkg::shs_sts_t sts,
    input  shs_pkg::shs_in_t  s_payload,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              m_valid,
    input  logic              m_ready,
    output shs_pkg::shs_out_t m_payload
);

    import shs_pkg::*;

    localparam int DC_W = $clog2(NUM_DIMS);
    localparam int PA_W = $clog2(DIGIT_STORE);

    function automatic logic [DC_W-1:0] reduce_dim(input logic [7:0] v);
        logic [15:0] r;
        r = {8'd0, v};
        for (int k = 7; k >= 0; k--) begin
            if (r >= (16'(NUM_DIMS) << k)) begin
                r = r - (16'(NUM_DIMS) << k);
            end
        end
        return r[DC_W-1:0];
    endfunction

    function automatic logic [16:0] prime_prefix(input int k);
        logic [16:0] s;
        s = '0;
        for (int j = 0; j < k; j++) begin
            s = s + 17'(PRIME_ROM[j]);
        end
        return s;
    endfunction

    logic [9:0]  prime_tab [NUM_DIMS];
    logic [16:0] base_tab  [NUM_DIMS];

    for (genvar g = 0; g < NUM_DIMS; g++) begin : g_rom
        assign prime_tab[g] = PRIME_ROM[g];
        assign base_tab[g]  = prime_prefix(g);
    end

    // Configuration.
    logic [4:0]         width_exp_reg;
    logic [3:0]         height_exp_reg;
    logic [16:0]        width_aligned_reg;
    logic [15:0]        height_aligned_reg;
    logic [31:0]        stride_reg;
    logic signed [16:0] coef_x_reg;
    logic signed [17:0] coef_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_exp_reg      <= '0;
            height_exp_reg     <= '0;
            width_aligned_reg  <= 17'd1;
            height_aligned_reg <= 16'd1;
            stride_reg         <= 32'd1;
            coef_x_reg         <= 17'sd1;
            coef_y_reg         <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_WIDTH_EXP:      width_exp_reg      <= cfg_data[4:0];
                CFG_HEIGHT_EXP:     height_exp_reg     <= cfg_data[3:0];
                CFG_WIDTH_ALIGNED:  width_aligned_reg  <= cfg_data[16:0];
                CFG_HEIGHT_ALIGNED: height_aligned_reg <= cfg_data[15:0];
                CFG_SAMPLE_STRIDE:  stride_reg         <= cfg_data;
                CFG_COEF_X:         coef_x_reg         <= $signed(cfg_data[16:0]);
                CFG_COEF_Y:         coef_y_reg         <= $signed(cfg_data[17:0]);
                default:            width_exp_reg      <= width_exp_reg;
            endcase
        end
    end

    shs_in_t in_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_reg <= s_payload;
        end
    end

    // Dividers.
    logic [63:0] div_dividend;
    logic [9:0]  div_divisor;
    logic        div_busy;
    logic [63:0] div_quo;
    logic [9:0]  div_rem;
    logic        mod_busy;
    logic [63:0] mod_quo;
    logic [31:0] mod_rem;

    // Sampler state.
    logic [63:0]        index_reg;
    logic [DC_W-1:0]    dc_reg;
    logic [15:0]        xs_reg, ys_reg;
    logic [30:0]        xr_reg;
    logic [23:0]        yr_reg;
    logic [4:0]         pcnt_reg;
    logic signed [34:0] cfx_reg, cfy_reg;
    logic signed [63:0] ax_reg, ay_reg;
    logic [47:0]        snp_reg;
    logic [63:0]        mix_reg;
    logic [9:0]         b_reg;
    logic [16:0]        base_reg;
    logic [4:0]         skip_reg;
    logic [63:0]        x_reg;
    logic [6:0]         i_reg;
    logic [6:0]         n_reg;
    logic               keep_reg;
    logic [7:0]         t_reg;
    logic [63:0]        q_reg;

    // Memories.
    logic [7:0]  perm_mem  [DIGIT_STORE];
    logic [7:0]  order_mem [NUM_DIMS];
    logic [7:0]  stack_mem [STACK_DEPTH];
    logic [7:0]  perm_q;
    logic        perm_ok_reg;
    logic [7:0]  order_q;
    logic [7:0]  stack_q;
    logic [7:0]  perm_data;
    logic [17:0] perm_raddr;
    logic [17:0] perm_waddr;
    logic [DC_W-1:0] sel_dim;

    assign perm_raddr = 18'(base_reg) + (cmd.perm_digit ? 18'(div_rem) : 18'd0);
    assign perm_waddr = 18'(in_reg.table_address);
    assign perm_data  = perm_ok_reg ? perm_q : 8'd0;
    assign sel_dim    = reduce_dim(order_q);

    always_ff @(posedge aclk) begin
        if (cmd.wr_digit && (perm_waddr < 18'(DIGIT_STORE))) begin
            perm_mem[perm_waddr[PA_W-1:0]] <= in_reg.table_data;
        end
        perm_q      <= perm_mem[perm_raddr[PA_W-1:0]];
        perm_ok_reg <= (perm_raddr < 18'(DIGIT_STORE));
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_order && (in_reg.table_address < 11'(NUM_DIMS))) begin
            order_mem[in_reg.table_address[DC_W-1:0]] <= in_reg.table_data;
        end
        order_q <= order_mem[dc_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.dig_push && keep_reg) begin
            stack_mem[n_reg[STACK_AW-1:0]] <= perm_data;
        end
        stack_q <= stack_mem[STACK_AW'(n_reg - 7'd1)];
    end

    // Base-3 digit of y: divide by 3 through a reciprocal, exact for 16 bits.
    logic [15:0] y_div3;
    logic [1:0]  y_mod3;
    logic [33:0] y_prod;

    assign y_prod = 34'(ys_reg) * 34'd43691;
    assign y_div3 = y_prod[32:17];
    assign y_mod3 = 2'(ys_reg - 16'(y_div3 * 16'd3));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
            dc_reg    <= '0;
        end else begin
            if (cmd.load_idx) begin
                index_reg <= in_reg.start_index;
                dc_reg    <= '0;
            end else if (cmd.px_final) begin
                index_reg <= mix_reg + 64'(snp_reg);
                dc_reg    <= '0;
            end else if (cmd.out_load) begin
                dc_reg <= (dc_reg == DC_W'(NUM_DIMS - 1)) ? '0 : dc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.px_init) begin
            xs_reg   <= in_reg.pixel_x;
            ys_reg   <= in_reg.pixel_y;
            xr_reg   <= '0;
            yr_reg   <= '0;
            pcnt_reg <= '0;
        end else if (cmd.px_step) begin
            if (pcnt_reg < width_exp_reg) begin
                xr_reg <= {xr_reg[29:0], xs_reg[0]};
                xs_reg <= {1'b0, xs_reg[15:1]};
            end
            if (pcnt_reg < {1'b0, height_exp_reg}) begin
                yr_reg <= 24'(yr_reg * 24'd3) + 24'(y_mod3);
                ys_reg <= y_div3;
            end
            pcnt_reg <= pcnt_reg + 5'd1;
        end
        if (cmd.px_mul1) begin
            cfy_reg <= 35'(coef_y_reg * $signed({1'b0, height_aligned_reg}));
            cfx_reg <= 35'(coef_x_reg * $signed({1'b0, width_aligned_reg}));
            snp_reg <= 48'(in_reg.sample_number) * 48'(stride_reg);
        end
        if (cmd.px_mul2) begin
            ax_reg <= 64'($signed({1'b0, xr_reg}) * cfy_reg);
            ay_reg <= 64'($signed({1'b0, yr_reg}) * cfx_reg);
        end
        if (cmd.px_sum) begin
            mix_reg <= 64'(ax_reg + ay_reg);
        end else if (cmd.px_fix) begin
            mix_reg <= (stride_reg == 32'd0) ? 64'd0 : 64'(stride_reg) - 64'(mod_rem);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.get_sel) begin
            b_reg    <= prime_tab[sel_dim];
            base_reg <= base_tab[sel_dim];
            x_reg    <= index_reg;
            i_reg    <= '0;
            n_reg    <= '0;
            if (dc_reg == DC_W'(0)) begin
                skip_reg <= width_exp_reg;
            end else if (dc_reg == DC_W'(1)) begin
                skip_reg <= {1'b0, height_exp_reg};
            end else begin
                skip_reg <= '0;
            end
        end else begin
            if (cmd.dig_take) begin
                x_reg    <= div_quo;
                i_reg    <= i_reg + 7'd1;
                keep_reg <= (i_reg >= 7'(skip_reg));
            end
            if (cmd.dig_push && keep_reg) begin
                n_reg <= n_reg + 7'd1;
            end else if (cmd.pop) begin
                n_reg <= n_reg - 7'd1;
            end
        end
        if (cmd.t_latch) begin
            t_reg <= perm_data;
        end
        if (cmd.q_latch) begin
            q_reg <= div_quo;
        end
    end

    always_comb begin
        case (cmd.dsel)
            DSEL_FIRST: begin
                div_dividend = 64'(t_reg) << 32;
                div_divisor  = b_reg - 10'd1;
            end
            DSEL_ACC: begin
                div_dividend = (64'(stack_q) << 32) + q_reg;
                div_divisor  = b_reg;
            end
            default: begin
                div_dividend = x_reg;
                div_divisor  = b_reg;
            end
        endcase
    end

    shs_div #(.DW(64), .VW(10), .SPC(4)) u_digit_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    shs_div #(.DW(64), .VW(32), .SPC(1)) u_mod_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (64'd0 - mix_reg),
        .divisor   (stride_reg),
        .busy      (mod_busy),
        .quotient  (mod_quo),
        .remainder (mod_rem)
    );

    // Output register.
    logic     m_valid_reg;
    shs_out_t m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_payload_reg.sample_value   <= (q_reg[63:32] == 32'd0) ? q_reg[31:0] : 32'd0;
            m_payload_reg.dimension_used <= 8'(dc_reg);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign sts.cmd_code    = in_reg.cmd;
    assign sts.px_done     = (pcnt_reg >= width_exp_reg) && (pcnt_reg >= {1'b0, height_exp_reg});
    assign sts.mix_neg     = mix_reg[63] && (mod_quo == mod_quo);
    assign sts.stride_zero = (stride_reg == 32'd0);
    assign sts.x_done      = (x_reg == 64'd0) || i_reg[6];
    assign sts.n_zero      = (n_reg == 7'd0);
    assign sts.div_busy    = div_busy;
    assign sts.mod_busy    = mod_busy;
    assign sts.out_free    = !m_valid_reg || m_ready;

endmodule

/* rtl/shs_chk.sv */
`timescale 1ns / 1ps

module shs_chk #(
    parameter int NUM_DIMS = 32
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input shs_pkg::shs_in_t  s_payload,
    input logic              m_valid,
    input logic              m_ready,
    input shs_pkg::shs_out_t m_payload
);

    import shs_pkg::*;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // No result is pending right after reset.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A result always names a dimension inside the configured range.
    a_dim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.dimension_used < 8'(NUM_DIMS)))
        else $error("dimension out of range");

    // A get request keeps the core busy in the next cycle.
    a_get_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_payload.cmd == CMD_GET) |=> !s_ready)
        else $error("ready right after a get request");

endmodule

bind scrambled_halton_sampler_core shs_chk #(.NUM_DIMS(NUM_DIMS)) u_shs_chk (.*);
